>>> rtl/core/arrt_pkg.sv
// Package for the address range registration table.
// Holds sizes, action and status codes, and the item and entry types.
// No dependencies; imported by arrt_match and address_range_registration_table.
package arrt_pkg;

    localparam int MAX_RANGES = 16;
    localparam int ADDR_W     = 64;
    localparam int ENTRY_W    = ADDR_W - 1;
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);
    localparam int IDX_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

    localparam logic ACT_REGISTER = 1'b0;
    localparam logic ACT_QUERY    = 1'b1;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TOO_LARGE   = 3'd1,
        ST_OVERLAP     = 3'd2,
        ST_FULL        = 3'd3,
        ST_ZERO_OR_OUT = 3'd4
    } t_status;

    // Latched transaction: start address and exact (non-wrapping) end address.
    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W:0]   stop;
    } t_item;

    // One stored half-open range [start, stop).
    typedef struct packed {
        logic [ENTRY_W-1:0] start;
        logic [ENTRY_W-1:0] stop;
    } t_entry;

endpackage

>>> rtl/core/arrt_match.sv
// Shared compare unit of the address range registration table.
// Tests one stored range against the current transaction: overlap or containment.
// Depends on arrt_pkg.
module arrt_match
    import arrt_pkg::*;
(
    input  t_item  i_item,
    input  t_entry i_entry,
    output logic   o_hit
);

    logic [ADDR_W:0] w_addr;
    logic [ADDR_W:0] w_start;
    logic [ADDR_W:0] w_end;
    logic            w_addr_below_end;

    assign w_addr  = {1'b0, i_item.addr};
    assign w_start = {2'b00, i_entry.start};
    assign w_end   = {2'b00, i_entry.stop};

    assign w_addr_below_end = w_addr < w_end;

    always_comb begin
        unique case (i_item.op)
            ACT_REGISTER: o_hit = w_addr_below_end && (w_start < i_item.stop);
            ACT_QUERY:    o_hit = (w_start <= w_addr) && w_addr_below_end
                                  && (i_item.stop <= w_end);
            default:      o_hit = 1'b0;
        endcase
    end

endmodule

>>> rtl/core/address_range_registration_table.sv
// Top level of the address range registration table.
// Holds the range memory and the scan sequencer; instantiates arrt_match.
// Depends on arrt_pkg and arrt_match.
//
// Usage:
//   A transaction is taken at a rising edge where start is high and busy is
//   low; i_action, i_address and i_length are sampled at that edge. Action 0
//   registers [address, address+length), action 1 asks whether that range lies
//   wholly inside one stored range. Exactly one result follows: o_success and
//   o_status are valid for the single cycle in which o_done is high.
//   A register transaction that fails the size or zero-length check skips
//   the scan and raises o_done from the done state. Every other transaction
//   scans the stored ranges one per cycle through a single compare unit fed
//   by a registered memory read, then passes through the done state and
//   raises o_done. busy stays high until the cycle in which o_done rises; a
//   new transaction may be accepted in that same cycle, so one transaction
//   occupies the block from its acceptance until its o_done.
//   Reset (synchronous, active low) empties the table by clearing the entry
//   count; stored ranges themselves are not cleared. The receiver cannot stall:
//   a result not taken in its o_done cycle is lost to it.
module address_range_registration_table
    import arrt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_action,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [ADDR_W-1:0] i_length,
    output logic              o_done,
    output logic              o_success,
    output logic [2:0]        o_status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state      r_state, n_state;
    t_item       r_item, n_item;
    t_status     r_pre, n_pre;
    t_status     r_status, n_status;
    logic        r_success, n_success;
    logic        r_done, n_done;
    logic        r_hit, n_hit;
    logic        r_rd_vld, n_rd_vld;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_count, n_count;

    // Range memory: one write port, one registered read port.
    t_entry      mem_range [MAX_RANGES];
    t_entry      r_rd_entry;
    logic        w_wr_en;
    t_entry      w_wr_entry;

    logic [ADDR_W:0] w_sum;
    logic        w_too_large;
    logic        w_zero;
    logic        w_accept;
    logic        w_full;
    logic        w_hit;

    assign busy      = (r_state != S_IDLE);
    assign o_done    = r_done;
    assign o_success = r_success;
    assign o_status  = r_status;

    assign w_accept    = start && !busy;
    assign w_sum       = {1'b0, i_address} + {1'b0, i_length};
    assign w_too_large = i_address[ADDR_W-1] || (|w_sum[ADDR_W:ADDR_W-1]);
    assign w_zero      = (i_length == '0);
    assign w_full      = (r_count == CNT_W'(MAX_RANGES));

    arrt_match u_match (
        .i_item  (r_item),
        .i_entry (r_rd_entry),
        .o_hit   (w_hit)
    );

    assign w_wr_entry.start = r_item.addr[ENTRY_W-1:0];
    assign w_wr_entry.stop  = r_item.stop[ENTRY_W-1:0];
    assign w_wr_en = (r_state == S_DONE) && (r_item.op == ACT_REGISTER)
                     && (r_pre == ST_OK) && !r_hit && !w_full;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem_range[r_count[IDX_W-1:0]] <= w_wr_entry;
        end
        r_rd_entry <= mem_range[r_idx[IDX_W-1:0]];
    end

    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_pre     = r_pre;
        n_status  = r_status;
        n_success = r_success;
        n_done    = 1'b0;
        n_hit     = r_hit;
        n_rd_vld  = 1'b0;
        n_idx     = r_idx;
        n_count   = r_count;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_item.op   = i_action;
                    n_item.addr = i_address;
                    n_item.stop = w_sum;
                    n_idx       = '0;
                    n_hit       = 1'b0;
                    // For a register, size, then zero length, decide before any scan.
                    if (i_action == ACT_REGISTER && w_too_large) begin
                        n_pre   = ST_TOO_LARGE;
                        n_state = S_DONE;
                    end else if (i_action == ACT_REGISTER && w_zero) begin
                        n_pre   = ST_ZERO_OR_OUT;
                        n_state = S_DONE;
                    end else begin
                        n_pre   = ST_OK;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Issue one read a cycle; compare the entry read a cycle ago.
                if (r_rd_vld && w_hit) begin
                    n_hit = 1'b1;
                end
                if (r_idx < r_count) begin
                    n_rd_vld = 1'b1;
                    n_idx    = r_idx + CNT_W'(1);
                end else if (!r_rd_vld) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
                if (r_item.op == ACT_QUERY) begin
                    n_status = r_hit ? ST_OK : ST_ZERO_OR_OUT;
                end else if (r_pre != ST_OK) begin
                    n_status = r_pre;
                end else if (r_hit) begin
                    n_status = ST_OVERLAP;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_OK;
                    n_count  = r_count + CNT_W'(1);
                end
                n_success = (n_status == ST_OK);
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_done    <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_count   <= '0;
            r_idx     <= '0;
            r_hit     <= 1'b0;
            r_pre     <= ST_OK;
            r_status  <= ST_OK;
            r_success <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_done    <= n_done;
            r_rd_vld  <= n_rd_vld;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_hit     <= n_hit;
            r_pre     <= n_pre;
            r_status  <= n_status;
            r_success <= n_success;
        end
        r_item <= n_item;
    end

    // Table never grows past its capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RANGES))
        else $error("range count above capacity");

    // An accepted transaction makes the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("accepted transaction did not raise busy");

    // A result is shown only once the sequencer has returned to idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // The table grows only with a successful registration result.
    a_count_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count != $past(r_count)) |->
            (o_done && o_success && r_item.op == ACT_REGISTER))
        else $error("range count changed without a registration");

    // Success agrees with the status code on every result.
    a_success_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_success == (r_status == ST_OK)))
        else $error("success flag disagrees with status");

endmodule
